>>> rtl/epoch_seconds_to_calendar_date_macros.svh
// Assertion macros shared by the calendar-date converter.
// Build with NO_ASSERTIONS defined to compile them away.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define EPCAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EPCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EPCAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define EPCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/epcal_pkg.sv
package epcal_pkg;

    localparam int unsigned SECS_W   = 32;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MON_W    = 4;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned DAYS_W   = 16;
    localparam int unsigned YLEN_W   = 9;
    localparam int unsigned OUT_W    = 24;

    // 86400 is 128 times 675: the seconds lose their low seven bits and the
    // rest is multiplied by the reciprocal of 675, rounded up to 35 fraction bits.
    localparam int unsigned SECS_SHIFT  = 7;
    localparam int unsigned SCALED_W    = SECS_W - SECS_SHIFT;
    localparam int unsigned RECIP_W     = 26;
    localparam int unsigned PROD_W      = SCALED_W + RECIP_W;
    localparam int unsigned RECIP_SHIFT = 35;

    localparam logic [RECIP_W-1:0] RECIP_675 = 26'd50903317;

    localparam logic [YEAR_W-1:0] FIRST_YEAR      = 12'd1970;
    localparam logic [YLEN_W-1:0] DAYS_LEAP       = 9'd366;
    localparam logic [YLEN_W-1:0] DAYS_COMMON     = 9'd365;
    localparam logic [DAY_W-1:0]  FEB_LEAP_DAYS   = 5'd29;

    // Residues of the first year, so leap tests need no division.
    localparam logic [1:0] FIRST_MOD4   = 2'd2;
    localparam logic [6:0] FIRST_MOD100 = 7'd70;
    localparam logic [8:0] FIRST_MOD400 = 9'd370;
    localparam logic [6:0] LAST_MOD100  = 7'd99;
    localparam logic [8:0] LAST_MOD400  = 9'd399;

    localparam logic [MON_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MON_W-1:0] MONTH_DEC = 4'd11;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_INIT  = 6'b000100,
        ST_YEAR  = 6'b001000,
        ST_MONTH = 6'b010000,
        ST_DONE  = 6'b100000
    } epcal_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic init;
        logic year_step;
        logic month_step;
        logic out_load;
    } epcal_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } epcal_status_t;

    // Days in each month of a common year, January first.
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon);
        logic [DAY_W-1:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/epcal_dp.sv
module epcal_dp
    import epcal_pkg::*;
(
    input  logic                 clk,
    input  logic [SECS_W-1:0]    secs,
    input  epcal_cmd_t           cmd,
    output epcal_status_t        status,
    output logic [DAY_W-1:0]     day_out,
    output logic [MON_W-1:0]     mon_out,
    output logic [YEAR_W-1:0]    year_out
);

    logic [SCALED_W-1:0] scaled_reg, scaled_next;
    logic [DAYS_W-1:0] days_reg, days_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [1:0]        m4_reg, m4_next;
    logic [6:0]        m100_reg, m100_next;
    logic [8:0]        m400_reg, m400_next;
    logic [MON_W-1:0]  mon_reg, mon_next;
    logic [DAY_W-1:0]  day_out_reg, day_out_next;
    logic [MON_W-1:0]  mon_out_reg, mon_out_next;
    logic [YEAR_W-1:0] year_out_reg, year_out_next;

    logic [PROD_W-1:0]  product;
    logic               leap;
    logic [YLEN_W-1:0]  ylen;
    logic [DAY_W-1:0]   mlen;

    // Whole days are the top bits of the seconds over 128 times the rounded-up
    // reciprocal of 675. The rounding error stays below one part in 675 for
    // any 25-bit value, so the quotient is exact.
    assign product = {{(PROD_W-SCALED_W){1'b0}}, scaled_reg}
                     * {{(PROD_W-RECIP_W){1'b0}}, RECIP_675};

    assign leap = ((m4_reg == 2'd0) && (m100_reg != 7'd0)) || (m400_reg == 9'd0);
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = (leap && (mon_reg == MONTH_FEB)) ? FEB_LEAP_DAYS : month_len(mon_reg);

    assign status.year_done  = (days_reg < {{(DAYS_W-YLEN_W){1'b0}}, ylen});
    assign status.month_done = (days_reg < {{(DAYS_W-DAY_W){1'b0}}, mlen})
                               || (mon_reg == MONTH_DEC);

    always_comb
    begin
        scaled_next   = scaled_reg;
        days_next     = days_reg;
        year_next     = year_reg;
        m4_next       = m4_reg;
        m100_next     = m100_reg;
        m400_next     = m400_reg;
        mon_next      = mon_reg;
        day_out_next  = day_out_reg;
        mon_out_next  = mon_out_reg;
        year_out_next = year_out_reg;
        if (cmd.load)
        begin
            scaled_next = secs[SECS_W-1:SECS_SHIFT];
        end
        if (cmd.div_step)
        begin
            days_next = product[RECIP_SHIFT +: DAYS_W];
        end
        if (cmd.init)
        begin
            year_next = FIRST_YEAR;
            m4_next   = FIRST_MOD4;
            m100_next = FIRST_MOD100;
            m400_next = FIRST_MOD400;
            mon_next  = '0;
        end
        if (cmd.year_step)
        begin
            days_next = days_reg - {{(DAYS_W-YLEN_W){1'b0}}, ylen};
            year_next = year_reg + 12'd1;
            m4_next   = m4_reg + 2'd1;
            m100_next = (m100_reg == LAST_MOD100) ? 7'd0 : m100_reg + 7'd1;
            m400_next = (m400_reg == LAST_MOD400) ? 9'd0 : m400_reg + 9'd1;
        end
        if (cmd.month_step)
        begin
            days_next = days_reg - {{(DAYS_W-DAY_W){1'b0}}, mlen};
            mon_next  = mon_reg + 4'd1;
        end
        if (cmd.out_load)
        begin
            day_out_next  = days_reg[DAY_W-1:0] + 5'd1;
            mon_out_next  = mon_reg + 4'd1;
            year_out_next = year_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg   <= scaled_next;
        days_reg     <= days_next;
        year_reg     <= year_next;
        m4_reg       <= m4_next;
        m100_reg     <= m100_next;
        m400_reg     <= m400_next;
        mon_reg      <= mon_next;
        day_out_reg  <= day_out_next;
        mon_out_reg  <= mon_out_next;
        year_out_reg <= year_out_next;
    end

    assign day_out  = day_out_reg;
    assign mon_out  = mon_out_reg;
    assign year_out = year_out_reg;

endmodule

>>> rtl/epcal_ctrl.sv
module epcal_ctrl
    import epcal_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  epcal_status_t status,
    output epcal_cmd_t    cmd
);

    epcal_state_t      state_reg, state_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (status.year_done)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                if (status.month_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/epoch_seconds_to_calendar_date.sv
// Converts a count of local seconds since 1970-01-01 00:00 into a Gregorian date.
// Input channel: one request per 32-bit seconds count on s_axis_*; a request is
// taken when s_axis_tvalid and s_axis_tready are both high at a rising edge.
// Output channel: one date per request on m_axis_*, held in an output register
// until m_axis_tready takes it.
// Steps: a division by 86400 (a shift and a reciprocal multiplication), a set-up
// step, a walk that takes off one whole year at a time, a walk that takes off one
// whole month at a time, and the loading of the result. The year walk dominates.
// Throughput: one request at a time; s_axis_tready is high only while the
// converter is idle; no request is taken while one is worked on. A finished date
// may still wait in the output register while the next request is worked on.
// When the receiver stalls, a second finished date waits in the converter
// until the output register frees, and no new request is taken meanwhile.
// Reset (rst_n low, asynchronous) returns the controller to idle and empties
// the output register; no date is lost or invented after it.
`include "epoch_seconds_to_calendar_date_macros.svh"

module epoch_seconds_to_calendar_date
    import epcal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [SECS_W-1:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [4:0] day_of_month, [8:5] month_number,
                                              // [20:9] year_number, [23:21] zero
);

    epcal_cmd_t        cmd;
    epcal_status_t     status;
    logic [DAY_W-1:0]  day_of_month;
    logic [MON_W-1:0]  month_number;
    logic [YEAR_W-1:0] year_number;

    // The controller sequences division, year walk and month walk.
    epcal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the scaled seconds, days left, year and month.
    epcal_dp u_dp (
        .clk      (clk),
        .secs     (s_axis_tdata),
        .cmd      (cmd),
        .status   (status),
        .day_out  (day_of_month),
        .mon_out  (month_number),
        .year_out (year_number)
    );

    assign m_axis_tdata = {{(OUT_W-DAY_W-MON_W-YEAR_W){1'b0}},
                           year_number, month_number, day_of_month};

    // A date on the output always has a nonzero day and a month from 1 to 12.
    `EPCAL_ASSERT_IMP(a_day_month_range, clk, rst_n, m_axis_tvalid,
        (day_of_month != 5'd0) && (month_number != 4'd0) && (month_number <= 4'd12),
        "day or month out of range")

    // The year never leaves the span that a 32-bit count can reach.
    `EPCAL_ASSERT_IMP(a_year_range, clk, rst_n, m_axis_tvalid,
        (year_number >= 12'd1970) && (year_number <= 12'd2106),
        "year out of range")

    // Once a request is taken the converter is busy on the next cycle.
    `EPCAL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "request accepted while busy")

    // A result is loaded only into an empty or draining output register.
    `EPCAL_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load,
        !m_axis_tvalid || m_axis_tready, "output register overwritten")

endmodule
